[hw/rtl/tci_pkg.sv]
// Shared types and constants of the cheapest-insertion tour engine.
`default_nettype none
package tci_pkg;

  localparam int MAX_CITIES = 64;
  localparam int CITY_BITS  = $clog2(MAX_CITIES);
  localparam int DIST_BITS  = 32;
  localparam int COST_BITS  = DIST_BITS + 2;
  localparam int DADDR_BITS = 2 * CITY_BITS;

  localparam int IN_DATA_BITS  = 48;
  localparam int IN_USER_BITS  = 3;
  localparam int OUT_DATA_BITS = 48;

  typedef enum logic [2:0] {
    OP_WRITE_DIST = 3'd0,
    OP_START      = 3'd1,
    OP_BEST       = 3'd2,
    OP_INSERT     = 3'd3,
    OP_REMOVE     = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNLINKED = 2'd1,
    ST_IN_TOUR  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_W_D1,
    S_W_D2,
    S_W_D3,
    S_I_W1,
    S_I_W2,
    S_R_W,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CU_NOP,
    CU_LOAD,
    CU_ADD,
    CU_SUB_CMP
  } cu_op_t;

  typedef struct packed {
    cu_op_t op;
    logic   first;
  } cu_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/tci_cost_unit.sv]
// Shared add/subtract and compare unit that prices insertion positions.
`default_nettype none
module tci_cost_unit
  import tci_pkg::*;
(
  input  wire logic                        clk,
  input  wire cu_ctl_t                     ctl,
  input  wire logic [DIST_BITS-1:0]        dist_in,
  input  wire logic [CITY_BITS-1:0]        pos,
  output logic signed [COST_BITS-1:0]      min_cost,
  output logic [CITY_BITS-1:0]             min_pos
);

  logic signed [COST_BITS-1:0] acc_r;
  logic signed [COST_BITS-1:0] min_cost_r;
  logic [CITY_BITS-1:0]        min_pos_r;

  logic signed [COST_BITS-1:0] base;
  logic signed [COST_BITS-1:0] ext;
  logic signed [COST_BITS-1:0] sum;
  logic                        sub;
  logic                        better;

  // One adder serves all three terms; the third term is subtracted.
  always_comb begin
    sub    = (ctl.op == CU_SUB_CMP);
    base   = (ctl.op == CU_LOAD) ? '0 : acc_r;
    ext    = {{(COST_BITS-DIST_BITS){1'b0}}, dist_in};
    sum    = base + (sub ? ~ext : ext) + {{(COST_BITS-1){1'b0}}, sub};
    better = ctl.first || (sum < min_cost_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.op != CU_NOP) begin
      acc_r <= sum;
    end
    if (sub && better) begin
      min_cost_r <= sum;
      min_pos_r  <= pos;
    end
  end

  assign min_cost = min_cost_r;
  assign min_pos  = min_pos_r;

endmodule
`default_nettype wire

[hw/rtl/tour_cheapest_insertion.sv]
// Top level of the cheapest-insertion tour engine.
`default_nettype none
// The engine keeps a 64 x 64 distance memory of unsigned 16.16 values and a
// tour stored as a doubly linked ring of cities with one linked flag per city.
// Each input transaction carries an opcode in in_tuser and returns exactly one
// result transaction. The block takes one transaction at a time: in_tready is
// high only while the sequencer is idle, and a finished result sits in the
// output register so that the next transaction can be taken while it waits.
// From acceptance every transaction runs an execute state and then a finish
// state that waits for a free output register. A successful remove adds a
// write state, insert after two, and best insertion three read states for
// each of up to 64 ring entries. The walk is paced by the single read port
// of the distance memory, which delivers the three distances of each ring
// entry one per cycle into a shared add/subtract and compare unit. Reading
// a distance entry that was never written gives an undefined result.
module tour_cheapest_insertion
  import tci_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0 up: city_a[5:0], city_b[11:6], distance_value[43:12],
  // zero fill.
  input  wire logic [IN_DATA_BITS-1:0]   in_tdata,
  // Fields from bit 0 up: opcode[2:0].
  input  wire logic [IN_USER_BITS-1:0]   in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // Fields from bit 0 up: status[1:0], min_cost[35:2], city_out[41:36],
  // zero fill.
  output logic [OUT_DATA_BITS-1:0]       out_tdata
);

  state_t state_r, state_nxt;

  // Latched transaction.
  opcode_t              op_r;
  logic [CITY_BITS-1:0] a_r;
  logic [CITY_BITS-1:0] b_r;
  logic [DIST_BITS-1:0] v_r;

  // Walk state.
  logic [CITY_BITS-1:0] p_r;
  logic [CITY_BITS-1:0] n_r;
  logic [CITY_BITS-1:0] steps_r;
  logic                 first_r;

  // Result staging and output register.
  status_t              res_status_r;
  status_t              exec_status;
  logic [CITY_BITS-1:0] res_city_r;
  logic                 res_use_cost_r;
  logic                 out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;

  logic [MAX_CITIES-1:0] linked_r;
  logic [MAX_CITIES-1:0] linked_nxt;

  // Memories: distances, successor and predecessor links.
  logic [DIST_BITS-1:0] dist_mem [MAX_CITIES*MAX_CITIES];
  logic [CITY_BITS-1:0] nx_mem   [MAX_CITIES];
  logic [CITY_BITS-1:0] pv_mem   [MAX_CITIES];

  logic [DIST_BITS-1:0] ds_q;
  logic [CITY_BITS-1:0] nx_q;
  logic [CITY_BITS-1:0] pv_q;

  logic                  ds_we;
  logic [DADDR_BITS-1:0] ds_raddr;
  logic                  nx_we;
  logic [CITY_BITS-1:0]  nx_waddr, nx_wdata, nx_raddr;
  logic                  pv_we;
  logic [CITY_BITS-1:0]  pv_waddr, pv_wdata, pv_raddr;

  cu_ctl_t                     cu_ctl;
  logic signed [COST_BITS-1:0] cu_min_cost;
  logic [CITY_BITS-1:0]        cu_min_pos;

  logic in_fire;
  logic out_free;
  logic walk_done;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The walk ends when it is back at its start city, or after visiting as
  // many entries as there are cities.
  assign walk_done = (n_r == a_r) || (&steps_r);

  tci_cost_unit u_cost (
    .clk      (clk),
    .ctl      (cu_ctl),
    .dist_in  (ds_q),
    .pos      (p_r),
    .min_cost (cu_min_cost),
    .min_pos  (cu_min_pos)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_BEST:   state_nxt = linked_r[a_r] ? S_W_D1 : S_FIN;
          OP_INSERT: state_nxt = (linked_r[a_r] && !linked_r[b_r]) ? S_I_W1 : S_FIN;
          OP_REMOVE: state_nxt = linked_r[b_r] ? S_R_W : S_FIN;
          default:   state_nxt = S_FIN;
        endcase
      end
      S_W_D1: state_nxt = S_W_D2;
      S_W_D2: state_nxt = S_W_D3;
      S_W_D3: state_nxt = walk_done ? S_FIN : S_W_D1;
      S_I_W1: state_nxt = S_I_W2;
      S_I_W2: state_nxt = S_FIN;
      S_R_W:  state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port and cost unit controls.
  always_comb begin
    ds_we    = 1'b0;
    ds_raddr = '0;
    nx_we    = 1'b0;
    nx_waddr = '0;
    nx_wdata = '0;
    nx_raddr = '0;
    pv_we    = 1'b0;
    pv_waddr = '0;
    pv_wdata = '0;
    pv_raddr = '0;
    cu_ctl   = '{op: CU_NOP, first: 1'b0};
    unique case (state_r)
      S_EXEC: begin
        unique case (op_r)
          OP_WRITE_DIST: ds_we = 1'b1;
          OP_START: begin
            nx_we    = 1'b1;
            nx_waddr = b_r;
            nx_wdata = b_r;
            pv_we    = 1'b1;
            pv_waddr = b_r;
            pv_wdata = b_r;
          end
          OP_BEST: begin
            nx_raddr = a_r;
            ds_raddr = {a_r, b_r};
          end
          OP_INSERT: nx_raddr = a_r;
          OP_REMOVE: begin
            nx_raddr = b_r;
            pv_raddr = b_r;
          end
          default: ;
        endcase
      end
      S_W_D1: begin
        // d(p,c) has arrived; fetch d(c,n) with the fresh successor.
        cu_ctl   = '{op: CU_LOAD, first: 1'b0};
        ds_raddr = {b_r, nx_q};
      end
      S_W_D2: begin
        cu_ctl   = '{op: CU_ADD, first: 1'b0};
        ds_raddr = {p_r, n_r};
      end
      S_W_D3: begin
        // Price this entry and already start reading for the next one.
        cu_ctl   = '{op: CU_SUB_CMP, first: first_r};
        nx_raddr = n_r;
        ds_raddr = {n_r, b_r};
      end
      S_I_W1: begin
        nx_we    = 1'b1;
        nx_waddr = a_r;
        nx_wdata = b_r;
        pv_we    = 1'b1;
        pv_waddr = nx_q;
        pv_wdata = b_r;
      end
      S_I_W2: begin
        nx_we    = 1'b1;
        nx_waddr = b_r;
        nx_wdata = n_r;
        pv_we    = 1'b1;
        pv_waddr = b_r;
        pv_wdata = a_r;
      end
      S_R_W: begin
        // Splice the city out unless only one neighbor is left.
        if (pv_q != nx_q) begin
          nx_we    = 1'b1;
          nx_waddr = pv_q;
          nx_wdata = nx_q;
          pv_we    = 1'b1;
          pv_waddr = nx_q;
          pv_wdata = pv_q;
        end
      end
      default: ;
    endcase
  end

  // Linked flags: a start clears them all and links one city, an insert links
  // the new city, and a remove unlinks the city and, when only one neighbor
  // was left, that neighbor as well.
  always_comb begin
    linked_nxt = linked_r;
    unique case (state_r)
      S_EXEC: begin
        if (op_r == OP_START) begin
          linked_nxt      = '0;
          linked_nxt[b_r] = 1'b1;
        end
      end
      S_I_W2: linked_nxt[b_r] = 1'b1;
      S_R_W: begin
        if (pv_q == nx_q) begin
          linked_nxt[pv_q] = 1'b0;
        end
        linked_nxt[b_r] = 1'b0;
      end
      default: ;
    endcase
  end

  // Status of the latched transaction, decided from the flags before it runs.
  always_comb begin
    exec_status = ST_OK;
    unique case (op_r)
      OP_BEST: begin
        if (!linked_r[a_r]) begin
          exec_status = ST_UNLINKED;
        end
      end
      OP_INSERT: begin
        if (!linked_r[a_r]) begin
          exec_status = ST_UNLINKED;
        end else if (linked_r[b_r]) begin
          exec_status = ST_IN_TOUR;
        end
      end
      OP_REMOVE: begin
        if (!linked_r[b_r]) begin
          exec_status = ST_UNLINKED;
        end
      end
      default: ;
    endcase
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (ds_we) begin
      dist_mem[{a_r, b_r}] <= v_r;
    end
    ds_q <= dist_mem[ds_raddr];
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      nx_mem[nx_waddr] <= nx_wdata;
    end
    nx_q <= nx_mem[nx_raddr];
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      pv_mem[pv_waddr] <= pv_wdata;
    end
    pv_q <= pv_mem[pv_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      linked_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      linked_r <= linked_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= opcode_t'(in_tuser[2:0]);
      a_r  <= in_tdata[CITY_BITS-1:0];
      b_r  <= in_tdata[2*CITY_BITS-1:CITY_BITS];
      v_r  <= in_tdata[2*CITY_BITS+DIST_BITS-1:2*CITY_BITS];
    end
    unique case (state_r)
      S_EXEC: begin
        res_status_r   <= exec_status;
        res_city_r     <= '0;
        res_use_cost_r <= (op_r == OP_BEST) && linked_r[a_r];
        if (op_r == OP_BEST) begin
          p_r     <= a_r;
          steps_r <= '0;
          first_r <= 1'b1;
        end
      end
      S_W_D1: n_r <= nx_q;
      S_W_D3: begin
        first_r <= 1'b0;
        steps_r <= steps_r + 1'b1;
        p_r     <= n_r;
      end
      S_I_W1: n_r <= nx_q;
      S_R_W:  res_city_r <= pv_q;
      S_FIN: begin
        if (out_free) begin
          out_data_r <= {{(OUT_DATA_BITS-2-COST_BITS-CITY_BITS){1'b0}},
                         (res_use_cost_r ? cu_min_pos : res_city_r),
                         (res_use_cost_r ? cu_min_cost : {COST_BITS{1'b0}}),
                         res_status_r};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // An accepted transaction always moves the sequencer into execution.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("accepted transaction did not start execution");

  // The walk never runs past one visit per city.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_D3 && (&steps_r)) |=> state_r == S_FIN)
    else $error("ring walk exceeded the city count");

  // A finished result is placed in the output register once it is free.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result was not loaded into the output register");

  // Starting a tour leaves exactly one linked city.
  a_start_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == OP_START) |=> $onehot(linked_r))
    else $error("start tour did not leave a single linked city");
`endif

endmodule
`default_nettype wire

[test/tour_cheapest_insertion_test.sv]
// Self-checking testbench of the cheapest-insertion tour engine, with a reply predictor.
`timescale 1ns / 1ps

// Every request transaction is applied to a predictor of the tour engine when
// it is accepted. The predictor keeps its own copy of the distance memory and
// of the city ring. The reply that it expects is queued, and each reply
// transaction is checked field by field against the oldest entry.
//
// The predictor never lets the engine read a distance entry that was never
// written. Before each cheapest-insertion query, every distance that the walk
// will read is written first if it is still unknown. Error cases that stop
// before the walk need no distances.
module tour_cheapest_insertion_test;
  import tci_pkg::*;

  // Opcodes that the engine ignores; they still return an all-zero reply.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // The watchdog allows for a full-ring walk many times over, plus long
  // stalls on the reply side.
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 250;

  typedef struct packed {
    status_t                status;
    logic [COST_BITS-1:0]   cost;
    logic [CITY_BITS-1:0]   city;
  } tour_reply_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata   = '0;
  logic [IN_USER_BITS-1:0]  in_tuser   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;

  // Predictor state: the distance memory with a written flag per entry, and
  // the ring as successor and predecessor tables with a linked flag per city.
  logic [DIST_BITS-1:0]     dist_mem   [MAX_CITIES*MAX_CITIES];
  bit                       dist_known [MAX_CITIES*MAX_CITIES];
  logic [CITY_BITS-1:0]     ring_next  [MAX_CITIES];
  logic [CITY_BITS-1:0]     ring_prev  [MAX_CITIES];
  bit                       in_ring    [MAX_CITIES];

  tour_reply_t              expected_replies [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int episode_size  = 4;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int op_count [8];
  int error_replies = 0;
  int longest_ring  = 0;

  tour_cheapest_insertion i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int ring_count();
    int total;
    total = 0;
    foreach (in_ring[i]) total += in_ring[i];
    return total;
  endfunction

  function automatic longint dist_at(logic [CITY_BITS-1:0] row, logic [CITY_BITS-1:0] col);
    return longint'(dist_mem[{row, col}]);
  endfunction

  // Applies one accepted request to the predictor state and returns the reply
  // that the engine must give for it.
  function automatic tour_reply_t apply_tour_op(logic [2:0] opc, logic [CITY_BITS-1:0] ca,
                                                logic [CITY_BITS-1:0] cb,
                                                logic [DIST_BITS-1:0] dv);
    tour_reply_t          r;
    logic [CITY_BITS-1:0] p;
    logic [CITY_BITS-1:0] n;
    logic [CITY_BITS-1:0] min_pos;
    longint               cost;
    longint               best;
    int                   steps;
    r.status = ST_OK;
    r.cost   = '0;
    r.city   = '0;
    op_count[opc]++;
    case (opc)
      OP_WRITE_DIST: begin
        dist_mem[{ca, cb}]   = dv;
        dist_known[{ca, cb}] = 1'b1;
      end
      OP_START: begin
        // Any earlier ring is dropped; only the flags are cleared.
        foreach (in_ring[i]) in_ring[i] = 1'b0;
        ring_next[cb] = cb;
        ring_prev[cb] = cb;
        in_ring[cb]   = 1'b1;
      end
      OP_BEST: begin
        if (!in_ring[ca]) begin
          r.status = ST_UNLINKED;
        end else begin
          if (ring_count() > longest_ring) longest_ring = ring_count();
          p       = ca;
          min_pos = ca;
          best    = 0;
          for (steps = 0; steps < MAX_CITIES; steps++) begin
            n    = ring_next[p];
            cost = dist_at(p, cb) + dist_at(cb, n) - dist_at(p, n);
            // Only a strictly lower cost moves the best position, so ties
            // keep the entry met first on the walk.
            if (steps == 0 || cost < best) begin
              best    = cost;
              min_pos = p;
            end
            p = n;
            if (p == ca) break;
          end
          r.cost = best[COST_BITS-1:0];
          r.city = min_pos;
        end
      end
      OP_INSERT: begin
        if (!in_ring[ca]) begin
          r.status = ST_UNLINKED;
        end else if (in_ring[cb]) begin
          r.status = ST_IN_TOUR;
        end else begin
          n             = ring_next[ca];
          ring_next[ca] = cb;
          ring_prev[cb] = ca;
          ring_next[cb] = n;
          ring_prev[n]  = cb;
          in_ring[cb]   = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!in_ring[cb]) begin
          r.status = ST_UNLINKED;
        end else begin
          p = ring_prev[cb];
          n = ring_next[cb];
          // With one or two cities the neighbor on both sides is the same,
          // and the ring falls apart completely.
          if (p == n) begin
            in_ring[p] = 1'b0;
          end else begin
            ring_next[p] = n;
            ring_prev[n] = p;
          end
          in_ring[cb] = 1'b0;
          r.city      = p;
        end
      end
      default: begin
      end
    endcase
    if (r.status != ST_OK) error_replies++;
    return r;
  endfunction

  function automatic logic [CITY_BITS-1:0] rand_city();
    return CITY_BITS'($urandom_range(0, MAX_CITIES - 1));
  endfunction

  // Returns a random city that is linked or unlinked as asked; the caller
  // makes sure that one exists.
  function automatic logic [CITY_BITS-1:0] pick_city(bit linked);
    logic [CITY_BITS-1:0] found [$];
    foreach (in_ring[i]) begin
      if (in_ring[i] == linked) found.push_back(CITY_BITS'(i));
    end
    return found[$urandom_range(0, found.size() - 1)];
  endfunction

  // Distances mix the extremes, small values that make close races between
  // positions, and fully random words.
  function automatic logic [DIST_BITS-1:0] rand_dist();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: return DIST_BITS'($urandom_range(0, 32'h0014_0000));
      default: return DIST_BITS'($urandom());
    endcase
  endfunction

  // Sends one request transaction, idling first at the current sender rate.
  // The valid stays high after acceptance so that back-to-back requests do
  // not drop it between them.
  task automatic send_op(input logic [2:0] opc, input logic [CITY_BITS-1:0] ca,
                         input logic [CITY_BITS-1:0] cb, input logic [DIST_BITS-1:0] dv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= opc;
    in_tdata  <= {{(IN_DATA_BITS - DIST_BITS - 2*CITY_BITS){1'b0}}, dv, cb, ca};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_replies.push_back(apply_tour_op(opc, ca, cb, dv));
  endtask

  // Writes every distance that the walk from start_city will read for city c
  // and that is still unknown, then asks for the cheapest insertion.
  task automatic ask_best(input logic [CITY_BITS-1:0] start_city,
                          input logic [CITY_BITS-1:0] c);
    logic [CITY_BITS-1:0] p;
    logic [CITY_BITS-1:0] n;
    logic [CITY_BITS-1:0] rows [3];
    logic [CITY_BITS-1:0] cols [3];
    int                   steps;
    if (in_ring[start_city]) begin
      p = start_city;
      for (steps = 0; steps < MAX_CITIES; steps++) begin
        n    = ring_next[p];
        rows = '{p, c, p};
        cols = '{c, n, n};
        for (int k = 0; k < 3; k++) begin
          if (!dist_known[{rows[k], cols[k]}])
            send_op(OP_WRITE_DIST, rows[k], cols[k], rand_dist());
        end
        p = n;
        if (p == start_city) break;
      end
    end
    send_op(OP_BEST, start_city, c, DIST_BITS'($urandom()));
  endtask

  // Stops sending and waits until every outstanding reply has come back.
  task automatic wait_all_replies();
    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // With no ring at all every ring opcode fails, and the spare opcodes are
  // ignored.
  task automatic test_empty_tour_errors();
    send_op(OP_BEST, 6'd7, 6'd9, '1);
    send_op(OP_INSERT, 6'd7, 6'd9, '0);
    send_op(OP_REMOVE, 6'd63, 6'd9, '0);
    for (int spare = OP_SPARE_FIRST; spare <= OP_SPARE_LAST; spare++)
      send_op(3'(spare), 6'd63, 6'd63, '1);
  endtask

  // Walks through the ring edits and the cost extremes on small rings of
  // cities 0, 5, 6, 10, 21 and 63.
  task automatic test_ring_edit_cases();
    send_op(OP_START, 6'd0, 6'd0, '0);
    // A one-city ring prices the city between the start and itself; with
    // both legs at the top value and no saving this is the largest cost.
    send_op(OP_WRITE_DIST, 6'd0, 6'd63, '1);
    send_op(OP_WRITE_DIST, 6'd63, 6'd0, '1);
    send_op(OP_WRITE_DIST, 6'd0, 6'd0, '0);
    ask_best(6'd0, 6'd63);
    send_op(OP_INSERT, 6'd0, 6'd63, '0);
    send_op(OP_INSERT, 6'd0, 6'd63, '0);
    send_op(OP_INSERT, 6'd5, 6'd6, '0);
    // Pricing a city that is already in the ring; both positions cost zero,
    // so the start of the walk must win the tie.
    ask_best(6'd63, 6'd0);
    // Free legs and the largest saving give the most negative cost.
    send_op(OP_WRITE_DIST, 6'd0, 6'd21, '0);
    send_op(OP_WRITE_DIST, 6'd21, 6'd63, '0);
    ask_best(6'd0, 6'd21);
    send_op(OP_INSERT, 6'd63, 6'd21, '1);
    send_op(OP_REMOVE, 6'd0, 6'd63, '0);
    // Removing from a two-city ring unlinks the other city as well.
    send_op(OP_REMOVE, 6'd0, 6'd21, '0);
    ask_best(6'd0, 6'd5);
    // A new start drops the earlier ring; the last city returns itself.
    send_op(OP_START, 6'd0, 6'd5, '0);
    send_op(OP_INSERT, 6'd5, 6'd6, '0);
    send_op(OP_START, 6'd63, 6'd10, '1);
    send_op(OP_REMOVE, 6'd0, 6'd6, '0);
    send_op(OP_REMOVE, 6'd63, 6'd10, '0);
  endtask

  // Fills the ring with every city, prices a city on the full ring, tries an
  // insert into it, thins the ring out and then drops it with a new start.
  task automatic test_full_ring();
    send_op(OP_START, rand_city(), rand_city(), DIST_BITS'($urandom()));
    while (ring_count() < MAX_CITIES)
      send_op(OP_INSERT, pick_city(1'b1), pick_city(1'b0), DIST_BITS'($urandom()));
    ask_best(pick_city(1'b1), rand_city());
    send_op(OP_INSERT, pick_city(1'b1), rand_city(), DIST_BITS'($urandom()));
    repeat (8) send_op(OP_REMOVE, rand_city(), pick_city(1'b1), DIST_BITS'($urandom()));
    send_op(OP_START, rand_city(), rand_city(), DIST_BITS'($urandom()));
    episode_size = 4;
  endtask

  // One random step of tour building. Most steps are well-formed edits and
  // queries on a ring that grows toward a small target size; the rest are
  // failing requests, stray distance writes and spare opcodes.
  task automatic random_tour_op();
    int                   sz;
    int                   roll;
    int                   kind;
    logic [2:0]           spare;
    sz   = ring_count();
    roll = $urandom_range(0, 99);
    if (sz == 0 || roll < 3) begin
      episode_size = $urandom_range(1, 12);
      send_op(OP_START, rand_city(), rand_city(), DIST_BITS'($urandom()));
    end else if (roll < 40) begin
      if (sz < episode_size)
        send_op(OP_INSERT, pick_city(1'b1), pick_city(1'b0), DIST_BITS'($urandom()));
      else
        send_op(OP_REMOVE, rand_city(), pick_city(1'b1), DIST_BITS'($urandom()));
    end else if (roll < 65) begin
      ask_best(pick_city(1'b1), rand_city());
    end else if (roll < 75) begin
      send_op(OP_REMOVE, rand_city(), pick_city(1'b1), DIST_BITS'($urandom()));
    end else if (roll < 88) begin
      kind = (sz == MAX_CITIES) ? 0 : $urandom_range(0, 3);
      case (kind)
        0: send_op(OP_INSERT, pick_city(1'b1), pick_city(1'b1), DIST_BITS'($urandom()));
        1: send_op(OP_INSERT, pick_city(1'b0), rand_city(), DIST_BITS'($urandom()));
        2: send_op(OP_REMOVE, rand_city(), pick_city(1'b0), DIST_BITS'($urandom()));
        default: send_op(OP_BEST, pick_city(1'b0), rand_city(), DIST_BITS'($urandom()));
      endcase
    end else if (roll < 97) begin
      send_op(OP_WRITE_DIST, rand_city(), rand_city(), rand_dist());
    end else begin
      spare = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      send_op(spare, rand_city(), rand_city(), DIST_BITS'($urandom()));
    end
  endtask

  task automatic test_random_tours(input int count);
    repeat (count) random_tour_op();
  endtask

  // Reply side: every accepted reply transaction is compared with the oldest
  // expected reply, and the ready is stalled at the current receiver rate.
  always @(posedge clk) begin : reply_check
    tour_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        $error("reply %h arrived with no request outstanding", out_tdata);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
          mismatches++;
        end
        if (out_tdata[COST_BITS+1:2] !== want.cost) begin
          $error("min_cost: expected %0d, got %0d", $signed(want.cost),
                 $signed(out_tdata[COST_BITS+1:2]));
          mismatches++;
        end
        if (out_tdata[COST_BITS+CITY_BITS+1:COST_BITS+2] !== want.city) begin
          $error("city_out: expected %0d, got %0d", want.city,
                 out_tdata[COST_BITS+CITY_BITS+1:COST_BITS+2]);
          mismatches++;
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // The watchdog counts cycles in which neither side moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The sender idles rarely and the receiver often.
    send_idle_pct = 12;
    recv_idle_pct = 52;
    test_empty_tour_errors();
    test_ring_edit_cases();
    test_random_tours(30);
    wait_all_replies();

    // The sender idles often and the receiver rarely.
    send_idle_pct = 52;
    recv_idle_pct = 12;
    test_full_ring();
    test_random_tours(30);
    wait_all_replies();

    // Both sides run flat out.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_tours(30);
    wait_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d distance writes, %0d tour starts, %0d insertion queries, %0d inserts,",
             op_count[OP_WRITE_DIST], op_count[OP_START], op_count[OP_BEST],
             op_count[OP_INSERT]);
    $display("%0d removes and %0d spare opcodes; %0d error replies, longest ring %0d cities.",
             op_count[OP_REMOVE],
             op_count[OP_SPARE_FIRST] + op_count[OP_SPARE_FIRST+1] + op_count[OP_SPARE_LAST],
             error_replies, longest_ring);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
